[design/rpy_pkg.sv]
// ----------------------------------------------------------------------------
// rpy_pkg
// Shared types and BT.601 integer coefficients for the RGB pair to YUY2 block.
// ----------------------------------------------------------------------------
package rpy_pkg;

   // widths of the lane arithmetic
   localparam int PIX_W  = 8;
   localparam int COEF_W = 9;
   localparam int PROD_W = PIX_W + 1 + COEF_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int SHIFT  = 8;
   localparam int LANE_W = SUM_W - SHIFT + 1;

   // rounding term added before the shift
   localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(128);

   // one set of weights and the offset that follows the shift
   typedef struct packed {
      logic signed [COEF_W-1:0] kr;
      logic signed [COEF_W-1:0] kg;
      logic signed [COEF_W-1:0] kb;
      logic        [PIX_W-1:0]  off;
   } coef_type;

   localparam coef_type LUMA_COEF = '{kr: 9'sd66,  kg: 9'sd129, kb: 9'sd25,  off: 8'd16};
   localparam coef_type BLUE_COEF = '{kr: -9'sd38, kg: -9'sd74, kb: 9'sd112, off: 8'd128};
   localparam coef_type RED_COEF  = '{kr: 9'sd112, kg: -9'sd94, kb: -9'sd18, off: 8'd128};

   // one lane result before clamping
   typedef logic signed [LANE_W-1:0] lane_type;

endpackage

[design/rpy_lane.sv]
// ----------------------------------------------------------------------------
// rpy_lane
// One weighting lane: registered products, then sum, round, shift and offset.
// ----------------------------------------------------------------------------
module rpy_lane (
   input  logic                        clock,
   input  logic [rpy_pkg::PIX_W-1:0]   red,
   input  logic [rpy_pkg::PIX_W-1:0]   green,
   input  logic [rpy_pkg::PIX_W-1:0]   blue,
   input  rpy_pkg::coef_type           coef,
   output rpy_pkg::lane_type           lane_out
);
   import rpy_pkg::*;

   logic signed [PROD_W-1:0] prod_r_ff, prod_g_ff, prod_b_ff;
   logic signed [PROD_W-1:0] prod_r_in, prod_g_in, prod_b_in;
   logic signed [SUM_W-1:0]  sum;
   logic signed [SUM_W-SHIFT-1:0] shifted;

   // products of each channel with its weight
   always_comb begin
      prod_r_in = PROD_W'($signed({1'b0, red})   * coef.kr);
      prod_g_in = PROD_W'($signed({1'b0, green}) * coef.kg);
      prod_b_in = PROD_W'($signed({1'b0, blue})  * coef.kb);
   end

   always_ff @(posedge clock) begin
      prod_r_ff <= prod_r_in;
      prod_g_ff <= prod_g_in;
      prod_b_ff <= prod_b_in;
   end

   // sum with rounding, floor shift, then offset
   always_comb begin
      sum      = SUM_W'(prod_r_ff) + SUM_W'(prod_g_ff) + SUM_W'(prod_b_ff) + ROUND;
      shifted  = sum[SUM_W-1:SHIFT];
      lane_out = LANE_W'(shifted) + LANE_W'($signed({1'b0, coef.off}));
   end

endmodule

[design/rpy_merge.sv]
// ----------------------------------------------------------------------------
// rpy_merge
// Clamps the four lane results and registers them as one YUY2 group.
// ----------------------------------------------------------------------------
module rpy_merge (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        lane_valid,
   input  rpy_pkg::lane_type           luma_left,
   input  rpy_pkg::lane_type           chroma_blue,
   input  rpy_pkg::lane_type           luma_right,
   input  rpy_pkg::lane_type           chroma_red,
   output logic                        rsp_valid,
   output logic [rpy_pkg::PIX_W-1:0]   rsp_luma_left,
   output logic [rpy_pkg::PIX_W-1:0]   rsp_chroma_blue,
   output logic [rpy_pkg::PIX_W-1:0]   rsp_luma_right,
   output logic [rpy_pkg::PIX_W-1:0]   rsp_chroma_red
);
   import rpy_pkg::*;

   localparam lane_type BYTE_MIN = LANE_W'(0);
   localparam lane_type BYTE_MAX = LANE_W'(255);

   function automatic logic [PIX_W-1:0] clamp_byte(input lane_type x);
      logic [PIX_W-1:0] r;
      if (x < BYTE_MIN) begin
         r = '0;
      end else if (x > BYTE_MAX) begin
         r = '1;
      end else begin
         r = x[PIX_W-1:0];
      end
      return r;
   endfunction

   logic                valid_ff;
   logic [PIX_W-1:0]    ll_ff, cb_ff, lr_ff, cr_ff;

   // strobe follows the lane stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= lane_valid;
      end
   end

   // clamped group register
   always_ff @(posedge clock) begin
      ll_ff <= clamp_byte(luma_left);
      cb_ff <= clamp_byte(chroma_blue);
      lr_ff <= clamp_byte(luma_right);
      cr_ff <= clamp_byte(chroma_red);
   end

   assign rsp_valid       = valid_ff;
   assign rsp_luma_left   = ll_ff;
   assign rsp_chroma_blue = cb_ff;
   assign rsp_luma_right  = lr_ff;
   assign rsp_chroma_red  = cr_ff;

endmodule

[design/rgba_pair_to_yuy2_top.sv]
// ----------------------------------------------------------------------------
// rgba_pair_to_yuy2_top
// Converts one horizontal RGB pixel pair into one YUY2 group (Y0 U Y1 V).
// ----------------------------------------------------------------------------
//  channel   ports               handshake
//  request   start, busy, req_*  taken when start is high and busy is low
//  result    rsp_valid, rsp_*    one-cycle strobe, cannot be held off
//
//  one request per cycle; busy is always low
//  each result is registered twice on its way out: first in the lane
//  product registers, then in the clamp and output register
//  reset clears only the valid pipeline; nothing is kept between requests
// ----------------------------------------------------------------------------
module rgba_pair_to_yuy2_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [rpy_pkg::PIX_W-1:0]   req_red_left,
   input  logic [rpy_pkg::PIX_W-1:0]   req_green_left,
   input  logic [rpy_pkg::PIX_W-1:0]   req_blue_left,
   input  logic [rpy_pkg::PIX_W-1:0]   req_red_right,
   input  logic [rpy_pkg::PIX_W-1:0]   req_green_right,
   input  logic [rpy_pkg::PIX_W-1:0]   req_blue_right,
   output logic                        rsp_valid,
   output logic [rpy_pkg::PIX_W-1:0]   rsp_luma_left,
   output logic [rpy_pkg::PIX_W-1:0]   rsp_chroma_blue,
   output logic [rpy_pkg::PIX_W-1:0]   rsp_luma_right,
   output logic [rpy_pkg::PIX_W-1:0]   rsp_chroma_red
);
   import rpy_pkg::*;

   logic              req_accept;
   logic              lane_valid_ff;
   logic [PIX_W:0]    sum_r, sum_g, sum_b;
   logic [PIX_W-1:0]  avg_r, avg_g, avg_b;
   lane_type          ll_lane, cb_lane, lr_lane, cr_lane;

   assign busy       = 1'b0;
   assign req_accept = start && !busy;

   // channel-wise truncating average for the shared chroma
   always_comb begin
      sum_r = {1'b0, req_red_left}   + {1'b0, req_red_right};
      sum_g = {1'b0, req_green_left} + {1'b0, req_green_right};
      sum_b = {1'b0, req_blue_left}  + {1'b0, req_blue_right};
      avg_r = sum_r[PIX_W:1];
      avg_g = sum_g[PIX_W:1];
      avg_b = sum_b[PIX_W:1];
   end

   // valid for the lane stage
   always_ff @(posedge clock) begin
      if (reset) begin
         lane_valid_ff <= 1'b0;
      end else begin
         lane_valid_ff <= req_accept;
      end
   end

   // four lanes side by side
   rpy_lane u_lane_ll (
      .clock    (clock),
      .red      (req_red_left),
      .green    (req_green_left),
      .blue     (req_blue_left),
      .coef     (LUMA_COEF),
      .lane_out (ll_lane)
   );

   rpy_lane u_lane_cb (
      .clock    (clock),
      .red      (avg_r),
      .green    (avg_g),
      .blue     (avg_b),
      .coef     (BLUE_COEF),
      .lane_out (cb_lane)
   );

   rpy_lane u_lane_lr (
      .clock    (clock),
      .red      (req_red_right),
      .green    (req_green_right),
      .blue     (req_blue_right),
      .coef     (LUMA_COEF),
      .lane_out (lr_lane)
   );

   rpy_lane u_lane_cr (
      .clock    (clock),
      .red      (avg_r),
      .green    (avg_g),
      .blue     (avg_b),
      .coef     (RED_COEF),
      .lane_out (cr_lane)
   );

   // clamp and register the group
   rpy_merge u_merge (
      .clock           (clock),
      .reset           (reset),
      .lane_valid      (lane_valid_ff),
      .luma_left       (ll_lane),
      .chroma_blue     (cb_lane),
      .luma_right      (lr_lane),
      .chroma_red      (cr_lane),
      .rsp_valid       (rsp_valid),
      .rsp_luma_left   (rsp_luma_left),
      .rsp_chroma_blue (rsp_chroma_blue),
      .rsp_luma_right  (rsp_luma_right),
      .rsp_chroma_red  (rsp_chroma_red)
   );

`ifndef SYNTHESIS
   // every request yields a result after the lane and merge registers
   a_req_to_rsp : assert property (@(posedge clock) disable iff (reset)
      req_accept ##1 1'b1 |=> rsp_valid)
      else $error("request without result");

   // no result without a request that went through the lane and merge registers
   a_rsp_from_req : assert property (@(posedge clock)
      rsp_valid |-> $past(req_accept, 2))
      else $error("result without request");

   // luma stays in the nominal video range
   a_luma_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_luma_left >= 8'd16 && rsp_luma_left <= 8'd235 &&
                     rsp_luma_right >= 8'd16 && rsp_luma_right <= 8'd235))
      else $error("luma out of range");
`endif

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rgba_pair_to_yuy2_top. Pixel pair requests go in
// through the start/busy port, and every YUY2 group strobed out is compared
// field by field against an in-bench BT.601 conversion of the pair. A short
// directed list covers the extremes, then random pairs run under several
// sender idle patterns.
// ----------------------------------------------------------------------------
module testbench;

   import rpy_pkg::*;

   // BT.601 integer weights, offsets and rounding
   localparam int Y_KR = 66;
   localparam int Y_KG = 129;
   localparam int Y_KB = 25;
   localparam int U_KR = -38;
   localparam int U_KG = -74;
   localparam int U_KB = 112;
   localparam int V_KR = 112;
   localparam int V_KG = -94;
   localparam int V_KB = -18;
   localparam int ROUND_TERM = 128;
   localparam int LUMA_OFFSET = 16;
   localparam int CHROMA_OFFSET = 128;
   localparam int BYTE_MAX = 255;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 6;
   localparam int PHASE_PAIRS = 410;
   localparam int PAIR_W = 6 * PIX_W;

   // sender idle percentages per phase
   localparam int IDLE_NONE = 0;
   localparam int IDLE_SENDER = 55;
   localparam int IDLE_BOTH = 28;

   typedef struct packed {
      logic [PIX_W-1:0] red_left;
      logic [PIX_W-1:0] green_left;
      logic [PIX_W-1:0] blue_left;
      logic [PIX_W-1:0] red_right;
      logic [PIX_W-1:0] green_right;
      logic [PIX_W-1:0] blue_right;
   } pixel_pair_type;

   typedef struct packed {
      logic [PIX_W-1:0] luma_left;
      logic [PIX_W-1:0] chroma_blue;
      logic [PIX_W-1:0] luma_right;
      logic [PIX_W-1:0] chroma_red;
   } yuy2_group_type;

   // expected YUY2 groups and their comparison against the block
   class yuy2_scoreboard;
      yuy2_group_type expected_groups[$];
      int unsigned mismatches;
      int unsigned pairs_noted;
      int unsigned groups_checked;

      // weighted sum, rounded, floor shift by 8, offset, clamp to a byte
      static function logic [PIX_W-1:0] weigh_and_clamp(int kr, int kg, int kb,
                                                         int offset, int r, int g, int b);
         int sum;
         int lane;
         sum = kr * r + kg * g + kb * b + ROUND_TERM;
         lane = (sum >>> 8) + offset;
         if (lane < 0) return '0;
         if (lane > BYTE_MAX) return PIX_W'(BYTE_MAX);
         return PIX_W'(lane);
      endfunction

      static function yuy2_group_type yuy2_from_pair(pixel_pair_type p);
         yuy2_group_type g;
         int red_avg;
         int green_avg;
         int blue_avg;
         // chroma uses the truncating channel average of the pair
         red_avg   = (int'(p.red_left) + int'(p.red_right)) >> 1;
         green_avg = (int'(p.green_left) + int'(p.green_right)) >> 1;
         blue_avg  = (int'(p.blue_left) + int'(p.blue_right)) >> 1;
         g.luma_left = weigh_and_clamp(Y_KR, Y_KG, Y_KB, LUMA_OFFSET,
                                       p.red_left, p.green_left, p.blue_left);
         g.chroma_blue = weigh_and_clamp(U_KR, U_KG, U_KB, CHROMA_OFFSET,
                                         red_avg, green_avg, blue_avg);
         g.luma_right = weigh_and_clamp(Y_KR, Y_KG, Y_KB, LUMA_OFFSET,
                                        p.red_right, p.green_right, p.blue_right);
         g.chroma_red = weigh_and_clamp(V_KR, V_KG, V_KB, CHROMA_OFFSET,
                                        red_avg, green_avg, blue_avg);
         return g;
      endfunction

      function void note_pair(pixel_pair_type p);
         expected_groups.push_back(yuy2_from_pair(p));
         pairs_noted++;
      endfunction

      function void compare_field(string field, logic [PIX_W-1:0] exp_val,
                                  logic [PIX_W-1:0] act_val);
         if (exp_val !== act_val) begin
            mismatches++;
            $display("%0t mismatch on %s: expected %0d actual %0d",
                     $time, field, exp_val, act_val);
         end
      endfunction

      function void check_group(yuy2_group_type got);
         yuy2_group_type want;
         if (expected_groups.size() == 0) begin
            mismatches++;
            $display("%0t unexpected group: expected none actual %h", $time, got);
            return;
         end
         want = expected_groups.pop_front();
         groups_checked++;
         compare_field("luma_left", want.luma_left, got.luma_left);
         compare_field("chroma_blue", want.chroma_blue, got.chroma_blue);
         compare_field("luma_right", want.luma_right, got.luma_right);
         compare_field("chroma_red", want.chroma_red, got.chroma_red);
      endfunction

      function int pending();
         return expected_groups.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [PIX_W-1:0] req_red_left;
   logic [PIX_W-1:0] req_green_left;
   logic [PIX_W-1:0] req_blue_left;
   logic [PIX_W-1:0] req_red_right;
   logic [PIX_W-1:0] req_green_right;
   logic [PIX_W-1:0] req_blue_right;
   logic rsp_valid;
   logic [PIX_W-1:0] rsp_luma_left;
   logic [PIX_W-1:0] rsp_chroma_blue;
   logic [PIX_W-1:0] rsp_luma_right;
   logic [PIX_W-1:0] rsp_chroma_red;

   yuy2_scoreboard yuy2_board = new();
   int unsigned quiet_cycles;

   rgba_pair_to_yuy2_top dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_red_left    (req_red_left),
      .req_green_left  (req_green_left),
      .req_blue_left   (req_blue_left),
      .req_red_right   (req_red_right),
      .req_green_right (req_green_right),
      .req_blue_right  (req_blue_right),
      .rsp_valid       (rsp_valid),
      .rsp_luma_left   (rsp_luma_left),
      .rsp_chroma_blue (rsp_chroma_blue),
      .rsp_luma_right  (rsp_luma_right),
      .rsp_chroma_red  (rsp_chroma_red)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // request and result monitor with watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            yuy2_board.note_pair({req_red_left, req_green_left, req_blue_left,
                                  req_red_right, req_green_right, req_blue_right});
         end
         if (rsp_valid) begin
            yuy2_board.check_group({rsp_luma_left, rsp_chroma_blue,
                                    rsp_luma_right, rsp_chroma_red});
         end
      end
      if ((start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog: no activity for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // random pair: mostly uniform, some saturated channels, some flat pairs
   function automatic pixel_pair_type random_pair();
      pixel_pair_type p;
      int mode;
      mode = $urandom_range(9);
      p = PAIR_W'({$urandom, $urandom});
      if (mode == 0) begin
         p.red_left    = $urandom_range(1) ? 8'hff : 8'h00;
         p.green_left  = $urandom_range(1) ? 8'hff : 8'h00;
         p.blue_left   = $urandom_range(1) ? 8'hff : 8'h00;
         p.red_right   = $urandom_range(1) ? 8'hff : 8'h00;
         p.green_right = $urandom_range(1) ? 8'hff : 8'h00;
         p.blue_right  = $urandom_range(1) ? 8'hff : 8'h00;
      end else if (mode == 1) begin
         p.red_right   = p.red_left;
         p.green_right = p.green_left;
         p.blue_right  = p.blue_left;
      end
      return p;
   endfunction

   // drive one request; entered and left at a falling edge
   task automatic drive_pair(input pixel_pair_type p, input int idle_pct);
      bit taken;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start           <= 1'b1;
      req_red_left    <= p.red_left;
      req_green_left  <= p.green_left;
      req_blue_left   <= p.blue_left;
      req_red_right   <= p.red_right;
      req_green_right <= p.green_right;
      req_blue_right  <= p.blue_right;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !busy;
         @(negedge clock);
      end
   endtask

   // sender holds off until every expected group has come back
   task automatic wait_drained();
      start <= 1'b0;
      @(negedge clock);
      while (yuy2_board.pending() != 0) @(negedge clock);
   endtask

   task automatic run_phase(input int count, input int idle_pct);
      wait_drained();
      for (int i = 0; i < count; i++) drive_pair(random_pair(), idle_pct);
   endtask

   // directed extremes: black, white, primaries, secondaries, split pairs, odd averages
   task automatic run_directed();
      pixel_pair_type list[$];
      list.push_back({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
      list.push_back({8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
      list.push_back({8'hff, 8'h00, 8'h00, 8'hff, 8'h00, 8'h00});
      list.push_back({8'h00, 8'hff, 8'h00, 8'h00, 8'hff, 8'h00});
      list.push_back({8'h00, 8'h00, 8'hff, 8'h00, 8'h00, 8'hff});
      list.push_back({8'h00, 8'hff, 8'hff, 8'h00, 8'hff, 8'hff});
      list.push_back({8'hff, 8'h00, 8'hff, 8'hff, 8'h00, 8'hff});
      list.push_back({8'hff, 8'hff, 8'h00, 8'hff, 8'hff, 8'h00});
      list.push_back({8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00});
      list.push_back({8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff});
      list.push_back({8'hff, 8'h00, 8'h00, 8'h00, 8'hff, 8'h00});
      list.push_back({8'h01, 8'h02, 8'h03, 8'h00, 8'h01, 8'h02});
      list.push_back({8'h80, 8'h7f, 8'h80, 8'h7f, 8'h80, 8'h7f});
      list.push_back({8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55});
      list.push_back({8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa});
      foreach (list[i]) drive_pair(list[i], IDLE_NONE);
   endtask

   // stimulus and end of run
   initial begin
      reset           <= 1'b1;
      start           <= 1'b0;
      req_red_left    <= '0;
      req_green_left  <= '0;
      req_blue_left   <= '0;
      req_red_right   <= '0;
      req_green_right <= '0;
      req_blue_right  <= '0;
      quiet_cycles    <= 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();
      run_phase(PHASE_PAIRS, IDLE_NONE);
      run_phase(PHASE_PAIRS, IDLE_SENDER);
      run_phase(PHASE_PAIRS, IDLE_NONE);
      run_phase(PHASE_PAIRS, IDLE_BOTH);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("converted %0d pixel pairs, checked %0d YUY2 groups, %0d mismatches",
               yuy2_board.pairs_noted, yuy2_board.groups_checked,
               yuy2_board.mismatches);
      $display("directed extremes plus random pairs, back to back and with idle gaps");
      if (yuy2_board.mismatches == 0 && yuy2_board.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
design/rpy_pkg.sv
design/rpy_lane.sv
design/rpy_merge.sv
design/rgba_pair_to_yuy2_top.sv
sim/testbench.sv
